>>> src/mbag_pkg.sv
// ----------------------------------------------------------------------------
// MCU block address generator - shared package
// Widths, register map, and the types passed between the front end, the
// request queue and the back end.
// ----------------------------------------------------------------------------
package mbag_pkg;

  localparam int unsigned BLOCK_SIDE_DEF = 8;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned MCU_W          = 13;
  localparam int unsigned BLKNUM_W       = 2;
  localparam int unsigned SHAPE_W        = 2;
  localparam int unsigned POS_W          = 6;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 4;

  localparam int unsigned S_TDATA_W      = 32;
  localparam int unsigned M_TDATA_W      = 40;

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_BLOCKS_ACROSS = 2'd2,
    REG_BLOCKS_DOWN   = 2'd3
  } mbag_reg_e;

  // MCU shape after folding 0 -> 1 and 3 -> 2
  typedef struct packed {
    logic across2;
    logic down2;
  } mbag_shape_t;

  // last valid row and column of the image
  typedef struct packed {
    logic [COORD_W-1:0] row_lim;
    logic [COORD_W-1:0] col_lim;
  } mbag_size_t;

  typedef struct packed {
    logic               bad;
    logic [COORD_W-1:0] base_row;
    logic [COORD_W-1:0] base_col;
  } mbag_entry_t;

  localparam int unsigned ENTRY_W = $bits(mbag_entry_t);

endpackage

>>> src/mcu_block_address_generator.sv
// ----------------------------------------------------------------------------
// MCU block address generator - top level
// Configuration registers, front end, request queue and back end.
// ----------------------------------------------------------------------------
// Each accepted request names an MCU (row, column) and one block inside it;
// the block answers with BLOCK_SIDE*BLOCK_SIDE words (64 for 8x8) carrying
// the source row and column of each pixel in raster order, tlast on the final
// one, with coordinates past the image edge clamped to the last row/column.
// A block number outside the MCU shape gives one word with tuser set, tlast
// set and zero coordinates. The back end produces one word per cycle unless
// m_axis_tready holds it off; a two-entry queue lets requests be taken while
// a block is still streaming. Registers are to be written over APB only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mcu_block_address_generator #(
  parameter int unsigned BLOCK_SIDE = mbag_pkg::BLOCK_SIDE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mbag_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mbag_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mbag_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // request stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // mcu_row[12:0], mcu_column[25:13], block_number[27:26], zero [31:28]
  input  logic [mbag_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,
  // address stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // source_row[15:0], source_column[31:16], position_in_block[37:32], zero [39:38]
  output logic [mbag_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  // bad_block[0]
  output logic                                m_axis_tuser_o
);
  import mbag_pkg::*;

  logic [COORD_W-1:0] image_width_q, image_height_q;
  logic [SHAPE_W-1:0] blocks_across_q, blocks_down_q;
  mbag_reg_e          reg_sel;
  logic               cfg_wr;

  mbag_shape_t        shape;
  mbag_size_t         size;
  mbag_entry_t        push_entry, head_entry;
  logic [ENTRY_W-1:0] head_bits;
  logic               q_ready, q_push, q_valid, q_pop;

  logic [COORD_W-1:0] src_row, src_col;
  logic [POS_W-1:0]   pos;

  assign pready  = 1'b1;
  assign reg_sel = mbag_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= COORD_W'(8);
      image_height_q  <= COORD_W'(8);
      blocks_across_q <= SHAPE_W'(1);
      blocks_down_q   <= SHAPE_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_IMAGE_WIDTH:   image_width_q   <= pwdata[COORD_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_q  <= pwdata[COORD_W-1:0];
        REG_BLOCKS_ACROSS: blocks_across_q <= pwdata[SHAPE_W-1:0];
        REG_BLOCKS_DOWN:   blocks_down_q   <= pwdata[SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(image_width_q);
      REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(image_height_q);
      REG_BLOCKS_ACROSS: prdata = APB_DATA_W'(blocks_across_q);
      REG_BLOCKS_DOWN:   prdata = APB_DATA_W'(blocks_down_q);
      default:           prdata = '0;
    endcase
  end

  // 0 counts as 1, 3 counts as 2
  assign shape.across2 = blocks_across_q[1];
  assign shape.down2   = blocks_down_q[1];
  assign size.row_lim  = (image_height_q == '0) ? '0 : image_height_q - 1'b1;
  assign size.col_lim  = (image_width_q == '0) ? '0 : image_width_q - 1'b1;

  mbag_front #(
    .BLOCK_SIDE (BLOCK_SIDE)
  ) u_front (
    .shape_i        (shape),
    .s_valid_i      (s_axis_tvalid_i),
    .s_ready_o      (s_axis_tready_o),
    .mcu_row_i      (s_axis_tdata_i[MCU_W-1:0]),
    .mcu_column_i   (s_axis_tdata_i[2*MCU_W-1:MCU_W]),
    .block_number_i (s_axis_tdata_i[2*MCU_W+BLKNUM_W-1:2*MCU_W]),
    .q_ready_i      (q_ready),
    .q_push_o       (q_push),
    .q_entry_o      (push_entry)
  );

  mbag_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_entry),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_bits)
  );

  assign head_entry = mbag_entry_t'(head_bits);

  mbag_back #(
    .BLOCK_SIDE (BLOCK_SIDE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .size_i          (size),
    .q_valid_i       (q_valid),
    .q_entry_i       (head_entry),
    .q_pop_o         (q_pop),
    .m_valid_o       (m_axis_tvalid_o),
    .m_ready_i       (m_axis_tready_i),
    .source_row_o    (src_row),
    .source_column_o (src_col),
    .position_o      (pos),
    .last_o          (m_axis_tlast_o),
    .bad_o           (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {(M_TDATA_W - 2 * COORD_W - POS_W)'(0), pos, src_col, src_row};

endmodule

>>> src/mbag_front.sv
// ----------------------------------------------------------------------------
// MCU block address generator - front end
// Accepts block requests, flags block numbers that do not fit the MCU shape,
// and computes the saturated block origin for the request queue.
// ----------------------------------------------------------------------------
module mbag_front #(
  parameter int unsigned BLOCK_SIDE = mbag_pkg::BLOCK_SIDE_DEF
) (
  input  mbag_pkg::mbag_shape_t                shape_i,
  input  logic                                 s_valid_i,
  output logic                                 s_ready_o,
  input  logic [mbag_pkg::MCU_W-1:0]           mcu_row_i,
  input  logic [mbag_pkg::MCU_W-1:0]           mcu_column_i,
  input  logic [mbag_pkg::BLKNUM_W-1:0]        block_number_i,
  input  logic                                 q_ready_i,
  output logic                                 q_push_o,
  output mbag_pkg::mbag_entry_t                q_entry_o
);
  import mbag_pkg::*;

  localparam int unsigned ORIG_W = MCU_W + $clog2(2 * BLOCK_SIDE) + 1;

  logic              bx, by;
  logic [ORIG_W-1:0] row_full, col_full;

  assign s_ready_o = q_ready_i;
  assign q_push_o  = s_valid_i && q_ready_i;

  always_comb begin
    bx = shape_i.across2 & block_number_i[0];
    by = shape_i.across2 ? block_number_i[1] : block_number_i[0];

    if (!shape_i.across2 && !shape_i.down2) begin
      q_entry_o.bad = (block_number_i != '0);
    end else if (shape_i.across2 && shape_i.down2) begin
      q_entry_o.bad = 1'b0;
    end else begin
      q_entry_o.bad = block_number_i[1];
    end

    row_full = ORIG_W'(mcu_row_i)
             * ORIG_W'(shape_i.down2 ? 2 * BLOCK_SIDE : BLOCK_SIDE)
             + (by ? ORIG_W'(BLOCK_SIDE) : '0);
    col_full = ORIG_W'(mcu_column_i)
             * ORIG_W'(shape_i.across2 ? 2 * BLOCK_SIDE : BLOCK_SIDE)
             + (bx ? ORIG_W'(BLOCK_SIDE) : '0);

    q_entry_o.base_row = (row_full > ORIG_W'(COORD_MAX)) ? COORD_MAX
                                                         : row_full[COORD_W-1:0];
    q_entry_o.base_col = (col_full > ORIG_W'(COORD_MAX)) ? COORD_MAX
                                                         : col_full[COORD_W-1:0];
  end

endmodule

>>> src/mbag_fifo.sv
// ----------------------------------------------------------------------------
// MCU block address generator - request queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module mbag_fifo #(
  parameter int unsigned WIDTH = mbag_pkg::ENTRY_W,
  parameter int unsigned DEPTH = mbag_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/mbag_back.sv
// ----------------------------------------------------------------------------
// MCU block address generator - back end
// Walks one queued block in raster order, clamps each coordinate to the image
// edge and drives the registered output word, zeroed for a bad block number.
// ----------------------------------------------------------------------------
module mbag_back #(
  parameter int unsigned BLOCK_SIDE = mbag_pkg::BLOCK_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbag_pkg::mbag_size_t          size_i,
  input  logic                          q_valid_i,
  input  mbag_pkg::mbag_entry_t         q_entry_i,
  output logic                          q_pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [mbag_pkg::COORD_W-1:0]  source_row_o,
  output logic [mbag_pkg::COORD_W-1:0]  source_column_o,
  output logic [mbag_pkg::POS_W-1:0]    position_o,
  output logic                          last_o,
  output logic                          bad_o
);
  import mbag_pkg::*;

  localparam int unsigned SIDE_W = (BLOCK_SIDE > 1) ? $clog2(BLOCK_SIDE) : 1;

  logic               busy_q, busy_d;
  logic [SIDE_W-1:0]  r_q, r_d, c_q, c_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  mbag_entry_t        cur_q;

  logic               out_free, emit, last_pix;
  logic [COORD_W:0]   row_sum, col_sum;
  logic [COORD_W-1:0] row_clamp, col_clamp;

  assign out_free = !m_valid_o || m_ready_i;
  assign emit     = busy_q && out_free;
  assign last_pix = cur_q.bad ||
                    ((r_q == SIDE_W'(BLOCK_SIDE - 1)) && (c_q == SIDE_W'(BLOCK_SIDE - 1)));
  assign q_pop_o  = q_valid_i && (!busy_q || (emit && last_pix));

  always_comb begin
    row_sum   = {1'b0, cur_q.base_row} + (COORD_W + 1)'(r_q);
    col_sum   = {1'b0, cur_q.base_col} + (COORD_W + 1)'(c_q);
    row_clamp = (row_sum > {1'b0, size_i.row_lim}) ? size_i.row_lim : row_sum[COORD_W-1:0];
    col_clamp = (col_sum > {1'b0, size_i.col_lim}) ? size_i.col_lim : col_sum[COORD_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    r_d    = r_q;
    c_d    = c_q;
    pos_d  = pos_q;
    if (q_pop_o) begin
      busy_d = 1'b1;
      r_d    = '0;
      c_d    = '0;
      pos_d  = '0;
    end else if (emit && last_pix) begin
      busy_d = 1'b0;
    end else if (emit) begin
      pos_d = pos_q + 1'b1;
      if (c_q == SIDE_W'(BLOCK_SIDE - 1)) begin
        c_d = '0;
        r_d = r_q + 1'b1;
      end else begin
        c_d = c_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      m_valid_o <= 1'b0;
      r_q       <= '0;
      c_q       <= '0;
      pos_q     <= '0;
    end else begin
      busy_q <= busy_d;
      r_q    <= r_d;
      c_q    <= c_d;
      pos_q  <= pos_d;
      if (emit) begin
        m_valid_o <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_entry_i;
    end
    if (emit) begin
      source_row_o    <= cur_q.bad ? '0 : row_clamp;
      source_column_o <= cur_q.bad ? '0 : col_clamp;
      position_o      <= cur_q.bad ? '0 : pos_q;
      last_o          <= last_pix;
      bad_o           <= cur_q.bad;
    end
  end

  ap_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && last_o && !bad_o |-> position_o == POS_W'(BLOCK_SIDE * BLOCK_SIDE - 1))
    else $error("last word of a block at wrong position");

  ap_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && bad_o |-> last_o && source_row_o == '0 && source_column_o == '0)
    else $error("bad block word not a single zeroed word");

  ap_pos_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q == POS_W'(r_q) * POS_W'(BLOCK_SIDE) + POS_W'(c_q))
    else $error("position counter out of step with row and column");

  ap_no_pop_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !(emit && last_pix) |-> !q_pop_o)
    else $error("queue popped while a block is in progress");

endmodule
